### rtl/core/ssp_pkg.sv
// Shared types and constants for the sprite screen projection block.
package ssp_pkg;

  typedef enum logic [2:0] {
    REG_PLAYER_X      = 3'd0,
    REG_PLAYER_Y      = 3'd1,
    REG_DIR_X         = 3'd2,
    REG_DIR_Y         = 3'd3,
    REG_PLANE_X       = 3'd4,
    REG_PLANE_Y       = 3'd5,
    REG_SCREEN_WIDTH  = 3'd6,
    REG_SCREEN_HEIGHT = 3'd7
  } cfg_reg_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int QUOT_W      = 16;

  localparam logic signed [15:0] RESET_PLAYER_X  = 16'sd0;
  localparam logic signed [15:0] RESET_PLAYER_Y  = 16'sd0;
  localparam logic signed [15:0] RESET_DIR_X     = 16'sd16384;
  localparam logic signed [15:0] RESET_DIR_Y     = 16'sd0;
  localparam logic signed [15:0] RESET_PLANE_X   = 16'sd0;
  localparam logic signed [15:0] RESET_PLANE_Y   = 16'sd10813;
  localparam logic [11:0]        RESET_SCREEN_W  = 12'd640;
  localparam logic [11:0]        RESET_SCREEN_H  = 12'd480;

endpackage

### rtl/core/ssp_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
module ssp_div import ssp_pkg::*; #(
  parameter int NW = 47,
  parameter int DW = 33,
  parameter int QB = 16,
  parameter int SW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QB-1:0] quot,
  output logic [SW-1:0] side_out
);

  localparam int CW = (NW > DW + QB) ? NW : DW + QB;

  logic          v_r    [0:QB];
  logic [NW-1:0] rem_r  [0:QB];
  logic [DW-1:0] den_r  [0:QB];
  logic [QB-1:0] q_r    [0:QB];
  logic          sat_r  [0:QB];
  logic [SW-1:0] side_r [0:QB];
  logic [NW-1:0] rem_nx [0:QB-1];
  logic          ge     [0:QB-1];
  logic          sat_in;

  assign sat_in = CW'(num) >= (CW'(den) << QB);

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int B = QB - 1 - k;
    logic [CW-1:0] dsh;
    logic [CW:0]   diff;
    assign dsh       = CW'(den_r[k]) << B;
    assign diff      = {1'b0, CW'(rem_r[k])} - {1'b0, dsh};
    assign ge[k]     = ~diff[CW];
    assign rem_nx[k] = ge[k] ? NW'(diff[CW-1:0]) : rem_r[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QB; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 0; k < QB; k++) v_r[k+1] <= v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= num;
      den_r[0]  <= den;
      q_r[0]    <= '0;
      sat_r[0]  <= sat_in;
      side_r[0] <= side_in;
      for (int k = 0; k < QB; k++) begin
        rem_r[k+1]  <= rem_nx[k];
        den_r[k+1]  <= den_r[k];
        q_r[k+1]    <= q_r[k] | (QB'(ge[k]) << (QB - 1 - k));
        sat_r[k+1]  <= sat_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = v_r[QB];
  assign quot      = sat_r[QB] ? '1 : q_r[QB];
  assign side_out  = side_r[QB];

endmodule

### rtl/core/sprite_screen_projection_top.sv
// Top level of the sprite screen projection pipeline.
//
// A sprite map position enters on the sprite channel (sprite_valid/sprite_ready)
// and one projected result leaves on the result channel (result_valid/result_ready).
// Camera position, direction, plane and screen size are written through the
// configuration port; the user must write them only while no transaction is in
// flight, which the block does not enforce. The pipeline accepts one transaction
// per cycle while the result channel does not stall. A result passes 41 register
// stages: five stages of subtraction, multiplication and sign handling, a 17-stage
// divider for depth and center column, one stage of saturation, a second 17-stage
// divider for sprite size, and the output register that computes the draw bounds.
// Reset clears all valid bits and loads the default camera and a 640 by 480
// screen. When the receiver holds result_ready low while a result waits, the
// whole pipeline holds and sprite_ready drops; nothing is lost or repeated.
module sprite_screen_projection_top import ssp_pkg::*; #(
  parameter int POS_FRAC_BITS = 8,
  parameter int VEC_FRAC_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   sprite_valid,
  output logic                   sprite_ready,
  input  logic signed [15:0]     sprite_x,
  input  logic signed [15:0]     sprite_y,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic                   valid_res,
  output logic                   visible,
  output logic signed [15:0]     depth,
  output logic signed [15:0]     center_column,
  output logic [15:0]            sprite_size,
  output logic [14:0]            start_column,
  output logic signed [15:0]     end_column,
  output logic [10:0]            start_row,
  output logic [11:0]            end_row
);

  localparam int N1W = 33 + VEC_FRAC_BITS;
  localparam int N3W = 12 + POS_FRAC_BITS;

  logic signed [15:0] player_x, player_y, dir_x, dir_y, plane_x, plane_y;
  logic [11:0]        screen_width, screen_height;
  logic               en;

  always_ff @(posedge clk) begin
    if (rst) begin
      player_x      <= RESET_PLAYER_X;
      player_y      <= RESET_PLAYER_Y;
      dir_x         <= RESET_DIR_X;
      dir_y         <= RESET_DIR_Y;
      plane_x       <= RESET_PLANE_X;
      plane_y       <= RESET_PLANE_Y;
      screen_width  <= RESET_SCREEN_W;
      screen_height <= RESET_SCREEN_H;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PLAYER_X:      player_x      <= cfg_data;
        REG_PLAYER_Y:      player_y      <= cfg_data;
        REG_DIR_X:         dir_x         <= cfg_data;
        REG_DIR_Y:         dir_y         <= cfg_data;
        REG_PLANE_X:       plane_x       <= cfg_data;
        REG_PLANE_Y:       plane_y       <= cfg_data;
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[11:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[11:0];
      endcase
    end
  end

  assign en           = ~result_valid | result_ready;
  assign sprite_ready = en;

  // Front stages.
  logic               va, vb, vc, vd, ve;
  logic signed [16:0] a_dx, a_dy;
  logic signed [32:0] b_ply_dx, b_plx_dy, b_dy_dx, b_dx_dy;
  logic signed [31:0] b_plx_dyv, b_dxv_ply;
  logic signed [33:0] c_nx, c_ny;
  logic signed [32:0] c_det;
  logic signed [33:0] ny_abs_s;
  logic signed [32:0] det_abs_s;
  logic [33:0]        d_asum;
  logic               d_sneg;
  logic signed [33:0] d_ny;
  logic signed [32:0] d_det;
  logic [N1W-1:0]     e_num1;
  logic [32:0]        e_den1;
  logic [44:0]        e_num2;
  logic [32:0]        e_den2;
  logic               e_neg1, e_neg2, e_detz;

  assign ny_abs_s  = d_ny[33] ? -d_ny : d_ny;
  assign det_abs_s = d_det[32] ? -d_det : d_det;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
    end else if (en) begin
      va <= sprite_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
    end
  end

  logic signed [34:0] sum_d;
  logic signed [34:0] sum_abs;
  assign sum_d   = 35'(c_ny) + 35'(c_nx);
  assign sum_abs = sum_d[34] ? -sum_d : sum_d;

  always_ff @(posedge clk) begin
    if (en) begin
      a_dx      <= 17'(sprite_x) - 17'(player_x);
      a_dy      <= 17'(sprite_y) - 17'(player_y);
      b_ply_dx  <= plane_y * a_dx;
      b_plx_dy  <= plane_x * a_dy;
      b_dy_dx   <= dir_y * a_dx;
      b_dx_dy   <= dir_x * a_dy;
      b_plx_dyv <= plane_x * dir_y;
      b_dxv_ply <= dir_x * plane_y;
      c_nx      <= 34'(b_dy_dx) - 34'(b_dx_dy);
      c_ny      <= 34'(b_ply_dx) - 34'(b_plx_dy);
      c_det     <= 33'(b_plx_dyv) - 33'(b_dxv_ply);
      d_asum    <= sum_abs[33:0];
      d_sneg    <= sum_d[34];
      d_ny      <= c_ny;
      d_det     <= c_det;
      e_num1    <= {ny_abs_s[32:0], VEC_FRAC_BITS'(0)};
      e_den1    <= det_abs_s[32:0];
      e_neg1    <= d_ny[33] ^ d_det[32];
      e_detz    <= (d_det == '0);
      e_num2    <= 45'(screen_width[11:1]) * 45'(d_asum);
      e_den2    <= ny_abs_s[32:0];
      e_neg2    <= d_sneg ^ d_ny[33];
    end
  end

  // Depth and center column dividers run side by side.
  logic              v1;
  logic [QUOT_W-1:0] q1, q2;
  logic [1:0]        side1;
  logic [0:0]        side2;

  ssp_div #(.NW(N1W), .DW(33), .QB(QUOT_W), .SW(2)) u_div_depth (
    .clk(clk), .rst(rst), .en(en), .in_valid(ve),
    .num(e_num1), .den(e_den1), .side_in({e_detz, e_neg1}),
    .out_valid(v1), .quot(q1), .side_out(side1)
  );

  ssp_div #(.NW(45), .DW(33), .QB(QUOT_W), .SW(1)) u_div_column (
    .clk(clk), .rst(rst), .en(en), .in_valid(ve),
    .num(e_num2), .den(e_den2), .side_in(e_neg2),
    .out_valid(), .quot(q2), .side_out(side2)
  );

  // Saturation of depth and center column.
  logic               vf, f_vres;
  logic signed [15:0] f_d, f_scx;
  logic [15:0]        f_dmag;
  logic [15:0]        dmag_c, cmag_c;

  assign dmag_c = side1[0] ? ((q1 > 16'd32768) ? 16'd32768 : q1)
                           : ((q1 > 16'd32767) ? 16'd32767 : q1);
  assign cmag_c = side2[0] ? ((q2 > 16'd32768) ? 16'd32768 : q2)
                           : ((q2 > 16'd32767) ? 16'd32767 : q2);

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_vres <= ~side1[1] & (dmag_c != '0);
      f_dmag <= dmag_c;
      f_d    <= side1[0] ? -dmag_c : dmag_c;
      f_scx  <= side2[0] ? -cmag_c : cmag_c;
    end
  end

  // Sprite size divider.
  logic              v3;
  logic [QUOT_W-1:0] q3;
  logic [32:0]       side3;

  ssp_div #(.NW(N3W), .DW(16), .QB(QUOT_W), .SW(33)) u_div_size (
    .clk(clk), .rst(rst), .en(en), .in_valid(vf),
    .num({screen_height, POS_FRAC_BITS'(0)}), .den(f_dmag),
    .side_in({f_vres, f_d, f_scx}),
    .out_valid(v3), .quot(q3), .side_out(side3)
  );

  // Draw bounds.
  logic               g_vres;
  logic signed [15:0] g_d, g_scx;
  logic [14:0]        half;
  logic [10:0]        half_h;
  logic signed [17:0] col_s, col_e, sw_s;
  logic signed [15:0] row_s;
  logic [15:0]        row_e;
  logic [14:0]        start_col_c;
  logic signed [15:0] end_col_c;
  logic [10:0]        start_row_c;
  logic [11:0]        end_row_c;

  assign g_vres = side3[32];
  assign g_d    = side3[31:16];
  assign g_scx  = side3[15:0];
  assign half   = q3[15:1];
  assign half_h = screen_height[11:1];
  assign col_s  = 18'(g_scx) - signed'({3'b0, half});
  assign col_e  = 18'(g_scx) + signed'({3'b0, half});
  assign sw_s   = signed'({6'b0, screen_width});
  assign row_s  = signed'({5'b0, half_h}) - signed'({1'b0, half});
  assign row_e  = {5'b0, half_h} + {1'b0, half};

  always_comb begin
    if (col_s < 0) begin
      start_col_c = '0;
    end else if (col_s > 18'sd32767) begin
      start_col_c = 15'h7fff;
    end else begin
      start_col_c = col_s[14:0];
    end
    end_col_c   = (col_e >= sw_s) ? 16'(screen_width) - 16'd1 : col_e[15:0];
    start_row_c = (row_s < 0) ? '0 : row_s[10:0];
    if (screen_height == '0) begin
      end_row_c = '0;
    end else if (row_e >= 16'(screen_height)) begin
      end_row_c = screen_height - 12'd1;
    end else begin
      end_row_c = row_e[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      valid_res     <= g_vres;
      visible       <= g_vres & ~g_d[15];
      depth         <= g_vres ? g_d : '0;
      center_column <= g_vres ? g_scx : '0;
      sprite_size   <= g_vres ? q3 : '0;
      start_column  <= g_vres ? start_col_c : '0;
      end_column    <= g_vres ? end_col_c : '0;
      start_row     <= g_vres ? start_row_c : '0;
      end_row       <= g_vres ? end_row_c : '0;
    end
  end

endmodule
